### sv/mp2_pkg.sv
// Package for the 2x2 max pooling stream: widths, defaults and register indexes.
`default_nettype none

package mp2_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed geometry and field widths.
    localparam int POOL_SIZE      = 2;
    localparam int POS_BITS       = 2;
    localparam int PWIDTH_BITS    = 11;
    localparam int PHEIGHT_BITS   = 13;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int ROW_BITS       = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    typedef logic [POS_BITS-1:0]       t_pos;

    // Configuration register indexes.
    localparam t_cfg_index REG_PLANE_WIDTH  = t_cfg_index'(0);
    localparam t_cfg_index REG_PLANE_HEIGHT = t_cfg_index'(1);

    // Window positions inside one 2x2 block.
    localparam t_pos POS_TL = t_pos'(0);
    localparam t_pos POS_TR = t_pos'(1);
    localparam t_pos POS_BL = t_pos'(2);
    localparam t_pos POS_BR = t_pos'(3);

endpackage

`default_nettype wire

### sv/mp2_if.sv
// Stream interfaces of the 2x2 max pooling block: samples, results and configuration.
`default_nettype none

// Sample channel: one input activation per word.
interface mp2_sample_if #(
    parameter int SAMPLE_BITS = mp2_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: block maximum, its position and the end-of-plane flag.
interface mp2_result_if #(
    parameter int SAMPLE_BITS = mp2_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled;
    logic [mp2_pkg::POS_BITS-1:0]  argmax_pos;
    logic                          plane_end;

    modport source (output valid, output pooled, output argmax_pos, output plane_end,
                    input ready);
    modport sink   (input valid, input pooled, input argmax_pos, input plane_end,
                    output ready);
endinterface

// Configuration write channel: register index and write data.
interface mp2_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mp2_pkg::CFG_INDEX_BITS-1:0] index;
    logic [mp2_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/max_pool_2x2_stream_top.sv
// Top level of the 2x2 stride-2 max pooling stream with its top-row pair buffer.
`default_nettype none

//  Channel    Dir  Word contents                         Accepted when
//  i_sample   in   sample                                valid && ready
//  o_result   out  pooled, argmax_pos, plane_end         valid && ready
//  i_cfg      in   index, data (0 width, 1 height)       valid && ready (ready always high)
//
//  One sample is taken per cycle unless sample input stalls; a result leaves after the
//  bottom-right sample of its block is accepted (pair buffer read, then final compare).
//  The pair buffer is single-port: at most one write or one read per accepted sample.
//  Reset clears the counters, the left sample and both pipeline valid flags; the pair
//  buffer is not cleared. A stalled result holds the compare stage, and the sample
//  channel stalls only while that stage is full and cannot move on.

module max_pool_2x2_stream_top #(
    parameter int MAX_WIDTH   = mp2_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = mp2_pkg::DEF_SAMPLE_BITS
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mp2_sample_if.sink    i_sample,
    mp2_result_if.source  o_result,
    mp2_cfg_if.sink       i_cfg
);
    import mp2_pkg::*;

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int EB    = (WB > PWIDTH_BITS) ? WB : PWIDTH_BITS;
    localparam int DEPTH = MAX_WIDTH / POOL_SIZE;
    localparam int AB    = CB - 1;

    // Configuration, stored already clamped to the legal range.
    logic [WB-1:0]           r_width;
    logic [PHEIGHT_BITS-1:0] r_height;
    logic [CB-1:0]           r_col;
    logic [ROW_BITS-1:0]     r_row;
    logic signed [SAMPLE_BITS-1:0] r_left;

    logic cfg_wr;
    logic [EB-1:0]           cfg_w_ext;
    logic [WB-1:0]           n_width;
    logic [PHEIGHT_BITS-1:0] n_height;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign cfg_w_ext   = EB'(i_cfg.data[PWIDTH_BITS-1:0]);

    // Clamp the written values.
    always_comb begin
        if (cfg_w_ext < EB'(2)) begin
            n_width = WB'(2);
        end else if (cfg_w_ext > EB'(MAX_WIDTH)) begin
            n_width = WB'(MAX_WIDTH);
        end else begin
            n_width = WB'(cfg_w_ext);
        end
        if (i_cfg.data[PHEIGHT_BITS-1:0] < PHEIGHT_BITS'(2)) begin
            n_height = PHEIGHT_BITS'(2);
        end else if (i_cfg.data[PHEIGHT_BITS-1:0] > PHEIGHT_BITS'(HEIGHT_LIMIT)) begin
            n_height = PHEIGHT_BITS'(HEIGHT_LIMIT);
        end else begin
            n_height = i_cfg.data[PHEIGHT_BITS-1:0];
        end
    end

    // Position decode of the next sample.
    logic          in_acc;
    logic          col_last;
    logic          row_last;
    logic          in_region;
    logic          col_odd;
    logic          row_odd;
    logic [CB-1:0] used_col_last;
    logic [ROW_BITS-1:0] used_row_last;
    logic [AB-1:0] pair_idx;
    logic          pair_right;
    logic signed [SAMPLE_BITS-1:0] pair_max;
    logic          do_left;
    logic          do_top;
    logic          do_bottom;

    assign in_acc        = i_sample.valid && i_sample.ready;
    assign col_last      = (r_col == CB'(r_width - WB'(1)));
    assign row_last      = (r_row == ROW_BITS'(r_height - PHEIGHT_BITS'(1)));
    assign used_col_last = CB'({r_width[WB-1:1], 1'b0} - WB'(1));
    assign used_row_last = ROW_BITS'({r_height[PHEIGHT_BITS-1:1], 1'b0} - PHEIGHT_BITS'(1));
    assign in_region     = !(col_last && r_width[0]) && !(row_last && r_height[0]);
    assign col_odd       = r_col[0];
    assign row_odd       = r_row[0];
    assign pair_idx      = r_col[CB-1:1];
    assign pair_right    = (i_sample.sample > r_left);
    assign pair_max      = pair_right ? i_sample.sample : r_left;
    assign do_left       = in_acc && in_region && !col_odd;
    assign do_top        = in_acc && in_region && col_odd && !row_odd;
    assign do_bottom     = in_acc && in_region && col_odd && row_odd;

    // Configuration registers, raster counters and left sample of the current pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WB'(2);
            r_height <= PHEIGHT_BITS'(2);
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
        end else begin
            if (cfg_wr && (i_cfg.index == REG_PLANE_WIDTH ||
                           i_cfg.index == REG_PLANE_HEIGHT)) begin
                if (i_cfg.index == REG_PLANE_WIDTH) begin
                    r_width <= n_width;
                end else begin
                    r_height <= n_height;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + ROW_BITS'(1);
                end else begin
                    r_col <= r_col + CB'(1);
                end
            end
            if (do_left) begin
                r_left <= i_sample.sample;
            end
        end
    end

    // Top-row pair buffer: written on top rows, read on bottom rows.
    logic [SAMPLE_BITS:0] r_mem [DEPTH];
    logic [SAMPLE_BITS:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (do_top) begin
            r_mem[pair_idx] <= {pair_right, pair_max};
        end
        if (do_bottom) begin
            r_rd <= r_mem[pair_idx];
        end
    end

    // Compare stage: bottom pair against the stored top pair.
    logic r_s1_valid;
    logic r_s1_bpos;
    logic r_s1_end;
    logic signed [SAMPLE_BITS-1:0] r_s1_bval;
    logic s1_adv;
    logic signed [SAMPLE_BITS-1:0] top_val;
    logic bottom_wins;

    assign s1_adv         = !o_result.valid || o_result.ready;
    assign i_sample.ready = !r_s1_valid || s1_adv;
    assign top_val        = $signed(r_rd[SAMPLE_BITS-1:0]);
    assign bottom_wins    = (r_s1_bval > top_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= do_bottom;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_bottom) begin
            r_s1_bval <= pair_max;
            r_s1_bpos <= pair_right;
            r_s1_end  <= (r_col == used_col_last) && (r_row == used_row_last);
        end
    end

    // Result register.
    logic r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_pooled;
    t_pos r_out_pos;
    logic r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_end <= r_s1_end;
            if (bottom_wins) begin
                r_out_pooled <= r_s1_bval;
                r_out_pos    <= r_s1_bpos ? POS_BR : POS_BL;
            end else begin
                r_out_pooled <= top_val;
                r_out_pos    <= r_rd[SAMPLE_BITS] ? POS_TR : POS_TL;
            end
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.pooled     = r_out_pooled;
    assign o_result.argmax_pos = r_out_pos;
    assign o_result.plane_end  = r_out_end;

endmodule

`default_nettype wire
